/* rtl/bdpt_pkg.sv */
// Shared types for the button debounce and press timer block.
package bdpt_pkg;

  localparam int unsigned CNT_W  = 8;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned DUR_W  = 32;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd20;

  // Per-sample decision from the debouncer
  typedef struct packed {
    logic press;
    logic release_ev;
    logic is_down;
  } bdpt_evt_t;

endpackage

/* rtl/bdpt_fsm.sv */
// Four-state debounce state machine with a shared dwell counter.
module bdpt_fsm (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     pin_level,
  input  logic [bdpt_pkg::CNT_W-1:0] debounce_samples,
  output bdpt_pkg::bdpt_evt_t      evt
);
  import bdpt_pkg::*;

  typedef enum logic [1:0] {
    ST_UP      = 2'd0,
    ST_DOWN    = 2'd1,
    ST_FALLING = 2'd2,
    ST_RISING  = 2'd3
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             expired;

  // Only one transient state is live at a time, so one counter serves both.
  assign expired = (cnt_r >= debounce_samples);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    evt.press      = 1'b0;
    evt.release_ev = 1'b0;
    unique case (state_r)
      ST_UP: begin
        if (!pin_level) state_nxt = ST_FALLING;
      end
      ST_FALLING: begin
        if (expired) begin
          cnt_nxt = '0;
          if (!pin_level) begin
            state_nxt = ST_DOWN;
            evt.press = 1'b1;
          end else begin
            state_nxt = ST_UP;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DOWN: begin
        if (pin_level) state_nxt = ST_RISING;
      end
      ST_RISING: begin
        if (expired) begin
          cnt_nxt = '0;
          if (pin_level) begin
            state_nxt      = ST_UP;
            evt.release_ev = 1'b1;
          end else begin
            state_nxt = ST_DOWN;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_UP;
      end
    endcase
    evt.is_down = (state_nxt == ST_DOWN) || (state_nxt == ST_RISING);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_UP;
      cnt_r   <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // stable states always hold a cleared counter
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UP || state_r == ST_DOWN) |-> (cnt_r == '0))
    else $error("dwell counter nonzero in stable state");

  // a confirmed press lands in down
  a_press_down: assert property (@(posedge clk) disable iff (!rst_n)
    (step && evt.press) |=> (state_r == ST_DOWN))
    else $error("press without entering down");

endmodule

/* rtl/bdpt_timer.sv */
// Press tick latch and press duration register.
module bdpt_timer #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [bdpt_pkg::TICK_W-1:0] tick_now,
  input  logic                      clear_duration,
  input  bdpt_pkg::bdpt_evt_t       evt,
  output logic [bdpt_pkg::DUR_W-1:0]  duration_nxt
);
  import bdpt_pkg::*;

  logic [TICK_WIDTH-1:0] tick_ext;
  logic [TICK_WIDTH-1:0] press_tick_r, press_tick_nxt;
  logic [TICK_WIDTH-1:0] duration_r, dur_full_nxt;

  // zero-extend or truncate the sampled tick to the counter width
  assign tick_ext = TICK_WIDTH'(tick_now);

  always_comb begin
    press_tick_nxt = evt.press ? tick_ext : press_tick_r;
    dur_full_nxt   = clear_duration ? '0 : duration_r;
    if (evt.release_ev) dur_full_nxt = tick_ext - press_tick_r;
  end

  assign duration_nxt = DUR_W'(dur_full_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_tick_r <= '0;
      duration_r   <= '0;
    end else if (step) begin
      press_tick_r <= press_tick_nxt;
      duration_r   <= dur_full_nxt;
    end
  end

endmodule

/* rtl/button_debounce_press_timer.sv */
// Top level: debounced active-low button with press duration timing.
//
// Each input transfer carries one raw pin sample (0 = pressed), the current
// tick count and a clear flag, and yields exactly one result transfer.
// The button walks up -> falling -> down -> rising -> up; a transient state
// waits cfg debounce_samples further samples (reset 20, written via
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, which
// the block does not enforce), then re-checks the pin, confirming the
// edge or falling back to the prior stable level. A confirmed press
// latches the tick; a confirmed release stores (release - press) modulo
// 2^TICK_WIDTH, reported in the low 32 bits of out_press_duration.
// clear_duration zeroes the stored duration before the sample acts. One
// sample per clock while in_stall is low; results come from one short
// combinational pass into the single output register. in_stall is high
// only while that register holds an untaken result and the sink stalls.
module button_debounce_press_timer #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [bdpt_pkg::CNT_W-1:0]  cfg_wr_data,
  // sample channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_pin_level,
  input  logic [bdpt_pkg::TICK_W-1:0] in_tick_now,
  input  logic                        in_clear_duration,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_press_event,
  output logic                        out_release_event,
  output logic                        out_is_down,
  output logic [bdpt_pkg::DUR_W-1:0]  out_press_duration
);
  import bdpt_pkg::*;

  logic [CNT_W-1:0] debounce_r;
  logic             in_xfer, out_xfer;
  bdpt_evt_t        evt;
  logic [DUR_W-1:0] duration_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_press_r, out_release_r, out_is_down_r;
  logic [DUR_W-1:0] out_duration_r;

  // Output register can take a new result whenever it is empty or drains now.
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
    end else if (cfg_wr_en) begin
      debounce_r <= cfg_wr_data;
    end
  end

  bdpt_fsm u_fsm (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (in_xfer),
    .pin_level        (in_pin_level),
    .debounce_samples (debounce_r),
    .evt              (evt)
  );

  bdpt_timer #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_timer (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (in_xfer),
    .tick_now       (in_tick_now),
    .clear_duration (in_clear_duration),
    .evt            (evt),
    .duration_nxt   (duration_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer)       out_valid_nxt = 1'b1;
    else if (out_xfer) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_press_r    <= evt.press;
      out_release_r  <= evt.release_ev;
      out_is_down_r  <= evt.is_down;
      out_duration_r <= duration_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_press_event    = out_press_r;
  assign out_release_event  = out_release_r;
  assign out_is_down        = out_is_down_r;
  assign out_press_duration = out_duration_r;

  a_press_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && evt.press) |=> (out_valid && out_press_event && out_is_down))
    else $error("press result lost or not down");

  a_release_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && evt.release_ev) |=> (out_valid && out_release_event && !out_is_down))
    else $error("release result lost or still down");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_clear_duration && !evt.release_ev) |=> (out_press_duration == '0))
    else $error("clear did not zero duration");

endmodule

/* bench/button_press_scoreboard_pkg.sv */
// Scoreboard class that predicts and checks the debounced button results.
`timescale 1ns / 1ps

package button_press_scoreboard_pkg;

  import bdpt_pkg::*;

  typedef enum logic [1:0] {
    BTN_UP      = 2'd0,
    BTN_DOWN    = 2'd1,
    BTN_FALLING = 2'd2,
    BTN_RISING  = 2'd3
  } btn_mode_e;

  typedef struct packed {
    logic             press;
    logic             release_ev;
    logic             is_down;
    logic [DUR_W-1:0] duration;
  } press_result_t;

  class press_timer_scoreboard;
    btn_mode_e         mode;
    logic [CNT_W-1:0]  debounce;
    logic [CNT_W-1:0]  fall_cnt;
    logic [CNT_W-1:0]  rise_cnt;
    logic [TICK_W-1:0] press_tick;
    logic [DUR_W-1:0]  duration;
    press_result_t     expected_q[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       presses;
    int unsigned       releases;

    function new();
      mode       = BTN_UP;
      debounce   = DEBOUNCE_RST;
      fall_cnt   = '0;
      rise_cnt   = '0;
      press_tick = '0;
      duration   = '0;
      errors     = 0;
      checked    = 0;
      presses    = 0;
      releases   = 0;
    endfunction

    function void set_debounce(logic [CNT_W-1:0] value);
      debounce = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the debouncer by one accepted sample and queue its result
    function void note_sample(logic pin, logic [TICK_W-1:0] tick, logic clr);
      press_result_t r;
      r = '0;
      if (clr) duration = '0;
      case (mode)
        BTN_UP: begin
          if (!pin) mode = BTN_FALLING;
        end
        BTN_FALLING: begin
          if (fall_cnt >= debounce) begin
            if (!pin) begin
              mode       = BTN_DOWN;
              press_tick = tick;
              r.press    = 1'b1;
              presses++;
            end else begin
              mode = BTN_UP;
            end
            fall_cnt = '0;
          end else begin
            fall_cnt = fall_cnt + 1'b1;
          end
        end
        BTN_DOWN: begin
          if (pin) mode = BTN_RISING;
        end
        BTN_RISING: begin
          if (rise_cnt >= debounce) begin
            if (pin) begin
              mode         = BTN_UP;
              duration     = tick - press_tick;
              r.release_ev = 1'b1;
              releases++;
            end else begin
              mode = BTN_DOWN;
            end
            rise_cnt = '0;
          end else begin
            rise_cnt = rise_cnt + 1'b1;
          end
        end
      endcase
      r.is_down  = (mode == BTN_DOWN) || (mode == BTN_RISING);
      r.duration = duration;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic press, logic release_ev, logic is_down,
                               logic [DUR_W-1:0] dur);
      press_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: press=%0d release=%0d down=%0d dur=%0h",
               press, release_ev, is_down, dur);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (press !== exp_r.press) begin
        $error("press_event: expected %0d, got %0d", exp_r.press, press);
        errors++;
      end
      if (release_ev !== exp_r.release_ev) begin
        $error("release_event: expected %0d, got %0d", exp_r.release_ev, release_ev);
        errors++;
      end
      if (is_down !== exp_r.is_down) begin
        $error("is_down: expected %0d, got %0d", exp_r.is_down, is_down);
        errors++;
      end
      if (dur !== exp_r.duration) begin
        $error("press_duration: expected %0h, got %0h", exp_r.duration, dur);
        errors++;
      end
    endfunction

    function void check_drained();
      if (expected_q.size() != 0) begin
        $error("%0d expected results never arrived", expected_q.size());
        errors += expected_q.size();
      end
    endfunction
  endclass

endpackage

/* bench/button_debounce_press_timer_tb.sv */
// Testbench top: drives button samples and checks debounced press timing.
`timescale 1ns / 1ps

module button_debounce_press_timer_tb;

  import bdpt_pkg::*;
  import button_press_scoreboard_pkg::*;

  // Clock, reset and every DUT input start at known values
  logic                clk;
  logic                rst_n             = 1'b0;
  logic                cfg_wr_en         = 1'b0;
  logic [CNT_W-1:0]    cfg_wr_data       = '0;
  logic                in_valid          = 1'b0;
  logic                in_pin_level      = 1'b1;
  logic [TICK_W-1:0]   in_tick_now       = '0;
  logic                in_clear_duration = 1'b0;
  logic                out_stall         = 1'b0;

  logic                in_stall;
  logic                out_valid;
  logic                out_press_event;
  logic                out_release_event;
  logic                out_is_down;
  logic [DUR_W-1:0]    out_press_duration;

  press_timer_scoreboard sb;

  // Stimulus knobs, changed between phases
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       debounce_now   = DEBOUNCE_RST;
  int unsigned       samples_sent   = 0;
  int unsigned       settings_used  = 1;
  logic [TICK_W-1:0] tick_ctr       = '0;

  button_debounce_press_timer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pin_level       (in_pin_level),
    .in_tick_now        (in_tick_now),
    .in_clear_duration  (in_clear_duration),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_press_event    (out_press_event),
    .out_release_event  (out_release_event),
    .out_is_down        (out_is_down),
    .out_press_duration (out_press_duration)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit: far above the slowest legal run (~800 samples, heavy stalls)
  initial begin
    #2_000_000;
    $display("button_debounce_press_timer_tb: FAIL");
    $finish;
  end

  // Sink side: random stall, redrawn every cycle at the current percentage
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor: outputs are read at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_press_event, out_release_event, out_is_down,
                      out_press_duration);
  end

  // One sample transfer. Entered and left in the time step of a clock edge;
  // random gaps first, then valid held with a steady payload until taken.
  task automatic send_sample(input logic pin, input logic [TICK_W-1:0] tick,
                             input logic clr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_pin_level      <= pin;
    in_tick_now       <= tick;
    in_clear_duration <= clr;
    do @(posedge clk); while (in_stall);
    sb.note_sample(pin, tick, clr);
    samples_sent++;
  endtask

  // Random tick progression: mostly small steps, sometimes a jump anywhere
  // (covers wrap between press and release), occasional clear.
  task automatic send_pin(input logic pin);
    if ($urandom_range(31) == 0)
      tick_ctr = $urandom;
    else
      tick_ctr = tick_ctr + $urandom_range(0, 5);
    send_sample(pin, tick_ctr, $urandom_range(15) == 0);
  endtask

  // Stop sending until every expected result has come back, then let the
  // output register settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Only called with the block drained
  task automatic write_debounce(input int unsigned value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[CNT_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_debounce(value[CNT_W-1:0]);
    debounce_now = value;
    settings_used++;
    @(posedge clk);
  endtask

  // Run length for one level of the pin. Mostly near the debounce window:
  // d+1 samples from a stable state just misses (decision sees the other
  // level), d+2 and up confirms. A quarter are short glitches.
  function automatic int unsigned level_len();
    if ($urandom_range(3) == 0)
      return $urandom_range(1, debounce_now + 1);
    return debounce_now + 1 + $urandom_range(0, 3);
  endfunction

  // Press/release episodes with random content, plus some raw pin noise.
  // Pauses once halfway so the pipe fully empties mid-stream.
  task automatic run_episodes(input int unsigned n_samples);
    int unsigned target;
    int unsigned half;
    int unsigned low_len;
    int unsigned high_len;
    int unsigned noise_len;
    bit          paused;
    target = samples_sent + n_samples;
    half   = samples_sent + n_samples / 2;
    paused = 1'b0;
    while (samples_sent < target) begin
      if (!paused && samples_sent >= half) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(7) == 0) begin
        noise_len = $urandom_range(4, 16);
        repeat (noise_len) send_pin(1'($urandom_range(1)));
      end else begin
        low_len  = level_len();
        high_len = level_len();
        repeat (low_len) send_pin(1'b0);
        repeat (high_len) send_pin(1'b1);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed, reset debounce of 20 ----
    // Idle sample with zero tick, then a press that bounces back: entry,
    // twenty counting samples (pin ignored), decision sees the pin released.
    send_sample(1'b1, 32'h0000_0000, 1'b0);
    send_sample(1'b0, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 20; i++)
      send_sample(i[0], 32'h1000_0000 + i, i[1]);
    send_sample(1'b1, 32'h1000_0020, 1'b0);
    drain_results();

    // ---- Directed, zero debounce: decisions on the first sample after entry
    write_debounce(0);
    send_sample(1'b0, 32'hFFFF_FFF0, 1'b0);  // enter falling
    send_sample(1'b0, 32'hFFFF_FFFA, 1'b0);  // press confirmed, tick latched
    send_sample(1'b1, 32'h0000_0000, 1'b0);  // enter rising
    send_sample(1'b0, 32'h0000_0001, 1'b0);  // release bounce, back to down
    send_sample(1'b1, 32'h0000_0002, 1'b0);  // enter rising again
    send_sample(1'b1, 32'h0000_0003, 1'b1);  // release with clear: wrap, dur 9
    send_sample(1'b1, 32'h0000_0004, 1'b1);  // clear alone zeroes duration
    send_sample(1'b1, 32'hFFFF_FFFF, 1'b0);
    drain_results();

    // ---- Random phases, each at its own setting and idling mix ----
    tick_ctr = $urandom;
    run_episodes(100);                   // zero debounce, no idling
    drain_results();

    write_debounce(3);
    send_idle_pct = 45;
    run_episodes(100);
    drain_results();

    write_debounce(1);
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    run_episodes(100);
    drain_results();

    write_debounce($urandom_range(2, 12));
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    run_episodes(100);
    drain_results();

    // Maximum debounce: counter runs all the way to 255 before the press
    // decision. Pin is random while counting since those samples ignore it.
    write_debounce(255);
    send_pin(1'b1);
    send_pin(1'b0);
    repeat (255) send_pin(1'($urandom_range(1)));
    send_pin(1'b0);
    drain_results();

    // Release the long press at a short setting and keep going
    write_debounce(2);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_episodes(60);
    drain_results();

    // Spare edges catch any stray result
    repeat (4) @(posedge clk);
    sb.check_drained();

    $display("Run covered %0d samples across %0d debounce settings (0, 1, 2, 3, 20, 255, random).",
             samples_sent, settings_used);
    $display("Checked %0d results: %0d presses and %0d releases confirmed, %0d errors.",
             sb.checked, sb.presses, sb.releases, sb.errors);
    if (sb.errors == 0)
      $display("button_debounce_press_timer_tb: PASS");
    else
      $display("button_debounce_press_timer_tb: FAIL");
    $finish;
  end

endmodule
